// ===== rtl/m6502s_pkg.sv =====
// shared types, codes and decode table for the 6502 subset core
package m6502s_pkg;

  localparam int MEM_DEPTH = 65536;
  localparam int AW        = $clog2(MEM_DEPTH);

  localparam logic [AW-1:0] RESET_PC     = 16'hFFFC;
  localparam logic [7:0]    RESET_SP     = 8'hFF;
  localparam logic [7:0]    OPC_JMP_ABS  = 8'h4C;
  localparam logic [7:0]    STACK_PAGE   = 8'h01;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_EXEC  = 2'd2;

  localparam logic [2:0] AM_IMM  = 3'd0;
  localparam logic [2:0] AM_ZP   = 3'd1;
  localparam logic [2:0] AM_ZPX  = 3'd2;
  localparam logic [2:0] AM_ZPY  = 3'd3;
  localparam logic [2:0] AM_ABS  = 3'd4;
  localparam logic [2:0] AM_ABX  = 3'd5;
  localparam logic [2:0] AM_ABY  = 3'd6;
  localparam logic [2:0] AM_NONE = 3'd7;

  localparam logic [3:0] OG_LDA  = 4'd0;
  localparam logic [3:0] OG_LDX  = 4'd1;
  localparam logic [3:0] OG_LDY  = 4'd2;
  localparam logic [3:0] OG_ADC  = 4'd3;
  localparam logic [3:0] OG_AND  = 4'd4;
  localparam logic [3:0] OG_ASL  = 4'd5;
  localparam logic [3:0] OG_ASLA = 4'd6;
  localparam logic [3:0] OG_JMP  = 4'd7;
  localparam logic [3:0] OG_JSR  = 4'd8;
  localparam logic [3:0] OG_RTS  = 4'd9;

  // datapath micro-operations, one per controller state
  localparam logic [4:0] UOP_CLR     = 5'd0;
  localparam logic [4:0] UOP_NOP     = 5'd1;
  localparam logic [4:0] UOP_ACCEPT  = 5'd2;
  localparam logic [4:0] UOP_WR      = 5'd3;
  localparam logic [4:0] UOP_RD      = 5'd4;
  localparam logic [4:0] UOP_RDW     = 5'd5;
  localparam logic [4:0] UOP_FOP     = 5'd6;
  localparam logic [4:0] UOP_DEC     = 5'd7;
  localparam logic [4:0] UOP_ZP_ADR  = 5'd8;
  localparam logic [4:0] UOP_AB_LO   = 5'd9;
  localparam logic [4:0] UOP_AB_HI   = 5'd10;
  localparam logic [4:0] UOP_EXRD    = 5'd11;
  localparam logic [4:0] UOP_EXEC    = 5'd12;
  localparam logic [4:0] UOP_PUSH_HI = 5'd13;
  localparam logic [4:0] UOP_PUSH_LO = 5'd14;
  localparam logic [4:0] UOP_PULL_LO = 5'd15;
  localparam logic [4:0] UOP_PULL_HI = 5'd16;
  localparam logic [4:0] UOP_RTS_END = 5'd17;
  localparam logic [4:0] UOP_DONE    = 5'd18;

  typedef struct packed {
    logic       ok;
    logic [3:0] grp;
    logic [2:0] mode;
  } dec_t;

  typedef struct packed {
    logic       clr_last;
    logic [1:0] cmd;
    logic       halt;
    dec_t       dec_now;
    dec_t       dec_r;
    logic       out_free;
  } ctrl_stat_t;

  typedef struct packed {
    logic [4:0] uop;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [7:0]  acc;
    logic [7:0]  x_reg;
    logic [7:0]  y_reg;
    logic [15:0] prog_counter;
    logic [7:0]  stack_ptr;
    logic        flag_n;
    logic        flag_v;
    logic        flag_z;
    logic        flag_c;
    logic        halted;
  } out_t;

  function automatic dec_t decode(input logic [7:0] op);
    dec_t d;
    d = '{ok: 1'b1, grp: OG_LDA, mode: AM_NONE};
    case (op)
      8'hA9: begin d.grp = OG_LDA; d.mode = AM_IMM; end
      8'hA5: begin d.grp = OG_LDA; d.mode = AM_ZP; end
      8'hB5: begin d.grp = OG_LDA; d.mode = AM_ZPX; end
      8'hAD: begin d.grp = OG_LDA; d.mode = AM_ABS; end
      8'hBD: begin d.grp = OG_LDA; d.mode = AM_ABX; end
      8'hB9: begin d.grp = OG_LDA; d.mode = AM_ABY; end
      8'hA2: begin d.grp = OG_LDX; d.mode = AM_IMM; end
      8'hA6: begin d.grp = OG_LDX; d.mode = AM_ZP; end
      8'hB6: begin d.grp = OG_LDX; d.mode = AM_ZPY; end
      8'hAE: begin d.grp = OG_LDX; d.mode = AM_ABS; end
      8'hBE: begin d.grp = OG_LDX; d.mode = AM_ABY; end
      8'hA0: begin d.grp = OG_LDY; d.mode = AM_IMM; end
      8'hA4: begin d.grp = OG_LDY; d.mode = AM_ZP; end
      8'hB4: begin d.grp = OG_LDY; d.mode = AM_ZPX; end
      8'hAC: begin d.grp = OG_LDY; d.mode = AM_ABS; end
      8'hBC: begin d.grp = OG_LDY; d.mode = AM_ABX; end
      8'h69: begin d.grp = OG_ADC; d.mode = AM_IMM; end
      8'h65: begin d.grp = OG_ADC; d.mode = AM_ZP; end
      8'h75: begin d.grp = OG_ADC; d.mode = AM_ZPX; end
      8'h6D: begin d.grp = OG_ADC; d.mode = AM_ABS; end
      8'h7D: begin d.grp = OG_ADC; d.mode = AM_ABX; end
      8'h79: begin d.grp = OG_ADC; d.mode = AM_ABY; end
      8'h29: begin d.grp = OG_AND; d.mode = AM_IMM; end
      8'h25: begin d.grp = OG_AND; d.mode = AM_ZP; end
      8'h35: begin d.grp = OG_AND; d.mode = AM_ZPX; end
      8'h2D: begin d.grp = OG_AND; d.mode = AM_ABS; end
      8'h3D: begin d.grp = OG_AND; d.mode = AM_ABX; end
      8'h39: begin d.grp = OG_AND; d.mode = AM_ABY; end
      8'h0A: begin d.grp = OG_ASLA; end
      8'h06: begin d.grp = OG_ASL; d.mode = AM_ZP; end
      8'h16: begin d.grp = OG_ASL; d.mode = AM_ZPX; end
      8'h0E: begin d.grp = OG_ASL; d.mode = AM_ABS; end
      8'h1E: begin d.grp = OG_ASL; d.mode = AM_ABX; end
      8'h4C: begin d.grp = OG_JMP; d.mode = AM_ABS; end
      8'h20: begin d.grp = OG_JSR; d.mode = AM_ABS; end
      8'h60: begin d.grp = OG_RTS; end
      default: d.ok = 1'b0;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/m6502s_if.sv =====
// command and result channel interfaces
interface m6502s_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] addr;
  logic [7:0]  data;
  modport source (output valid, cmd, addr, data, input ready);
  modport sink   (input valid, cmd, addr, data, output ready);
endinterface

interface m6502s_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic [7:0]  acc;
  logic [7:0]  x_reg;
  logic [7:0]  y_reg;
  logic [15:0] prog_counter;
  logic [7:0]  stack_ptr;
  logic        flag_n;
  logic        flag_v;
  logic        flag_z;
  logic        flag_c;
  logic        halted;
  modport source (output valid, read_data, acc, x_reg, y_reg, prog_counter, stack_ptr,
                  flag_n, flag_v, flag_z, flag_c, halted, input ready);
  modport sink   (input valid, read_data, acc, x_reg, y_reg, prog_counter, stack_ptr,
                  flag_n, flag_v, flag_z, flag_c, halted, output ready);
endinterface

// ===== rtl/m6502s_ram.sv =====
// generic single-port ram with registered read
module m6502s_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/m6502s_ctrl.sv =====
// sequencer: steps each command through its memory accesses
module m6502s_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  m6502s_pkg::ctrl_stat_t stat,
  output m6502s_pkg::ctrl_cmd_t  cmd
);
  localparam logic [4:0] S_CLR     = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_DISP    = 5'd2;
  localparam logic [4:0] S_WR      = 5'd3;
  localparam logic [4:0] S_RD      = 5'd4;
  localparam logic [4:0] S_RDW     = 5'd5;
  localparam logic [4:0] S_FOP     = 5'd6;
  localparam logic [4:0] S_DEC     = 5'd7;
  localparam logic [4:0] S_ZP_ADR  = 5'd8;
  localparam logic [4:0] S_AB_LO   = 5'd9;
  localparam logic [4:0] S_AB_HI   = 5'd10;
  localparam logic [4:0] S_EXRD    = 5'd11;
  localparam logic [4:0] S_EXEC    = 5'd12;
  localparam logic [4:0] S_PUSH_HI = 5'd13;
  localparam logic [4:0] S_PUSH_LO = 5'd14;
  localparam logic [4:0] S_PULL_LO = 5'd15;
  localparam logic [4:0] S_PULL_HI = 5'd16;
  localparam logic [4:0] S_RTS_END = 5'd17;
  localparam logic [4:0] S_DONE    = 5'd18;

  logic [4:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd.uop   = m6502s_pkg::UOP_NOP;
    case (state_r)
      S_CLR: begin
        cmd.uop = m6502s_pkg::UOP_CLR;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.uop   = m6502s_pkg::UOP_ACCEPT;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.cmd == m6502s_pkg::CMD_WRITE) state_nxt = S_WR;
        else if (stat.cmd == m6502s_pkg::CMD_READ) state_nxt = S_RD;
        else if (stat.cmd == m6502s_pkg::CMD_EXEC && !stat.halt) state_nxt = S_FOP;
        else state_nxt = S_DONE;
      end
      S_WR: begin
        cmd.uop   = m6502s_pkg::UOP_WR;
        state_nxt = S_DONE;
      end
      S_RD: begin
        cmd.uop   = m6502s_pkg::UOP_RD;
        state_nxt = S_RDW;
      end
      S_RDW: begin
        cmd.uop   = m6502s_pkg::UOP_RDW;
        state_nxt = S_DONE;
      end
      S_FOP: begin
        cmd.uop   = m6502s_pkg::UOP_FOP;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        cmd.uop = m6502s_pkg::UOP_DEC;
        if (!stat.dec_now.ok) state_nxt = S_DONE;
        else if (stat.dec_now.grp == m6502s_pkg::OG_RTS) state_nxt = S_PULL_LO;
        else if (stat.dec_now.mode == m6502s_pkg::AM_NONE) state_nxt = S_DONE;
        else if (stat.dec_now.mode == m6502s_pkg::AM_IMM) state_nxt = S_EXRD;
        else if (stat.dec_now.mode == m6502s_pkg::AM_ZP ||
                 stat.dec_now.mode == m6502s_pkg::AM_ZPX ||
                 stat.dec_now.mode == m6502s_pkg::AM_ZPY) state_nxt = S_ZP_ADR;
        else state_nxt = S_AB_LO;
      end
      S_ZP_ADR: begin
        cmd.uop   = m6502s_pkg::UOP_ZP_ADR;
        state_nxt = S_EXRD;
      end
      S_AB_LO: begin
        cmd.uop   = m6502s_pkg::UOP_AB_LO;
        state_nxt = S_AB_HI;
      end
      S_AB_HI: begin
        cmd.uop = m6502s_pkg::UOP_AB_HI;
        if (stat.dec_r.grp == m6502s_pkg::OG_JMP) state_nxt = S_DONE;
        else if (stat.dec_r.grp == m6502s_pkg::OG_JSR) state_nxt = S_PUSH_HI;
        else state_nxt = S_EXRD;
      end
      S_EXRD: begin
        cmd.uop   = m6502s_pkg::UOP_EXRD;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.uop   = m6502s_pkg::UOP_EXEC;
        state_nxt = S_DONE;
      end
      S_PUSH_HI: begin
        cmd.uop   = m6502s_pkg::UOP_PUSH_HI;
        state_nxt = S_PUSH_LO;
      end
      S_PUSH_LO: begin
        cmd.uop   = m6502s_pkg::UOP_PUSH_LO;
        state_nxt = S_DONE;
      end
      S_PULL_LO: begin
        cmd.uop   = m6502s_pkg::UOP_PULL_LO;
        state_nxt = S_PULL_HI;
      end
      S_PULL_HI: begin
        cmd.uop   = m6502s_pkg::UOP_PULL_HI;
        state_nxt = S_RTS_END;
      end
      S_RTS_END: begin
        cmd.uop   = m6502s_pkg::UOP_RTS_END;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.uop = m6502s_pkg::UOP_DONE;
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLR;
    endcase
  end
endmodule

// ===== rtl/m6502s_dp.sv =====
// datapath: registers, memory, alu and result register
module m6502s_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [1:0]             in_cmd,
  input  logic [15:0]            in_addr,
  input  logic [7:0]             in_data,
  input  m6502s_pkg::ctrl_cmd_t  cmd,
  output m6502s_pkg::ctrl_stat_t stat,
  input  logic                   out_ready,
  output logic                   out_valid,
  output m6502s_pkg::out_t       out_data
);
  logic [15:0] clr_cnt_r;
  logic [1:0]  cmd_r;
  logic [15:0] addr_r, ea_r, pc_r;
  logic [7:0]  data_r, lo_r, sp_r, a_r, x_r, y_r, rd_r;
  logic        n_r, v_r, z_r, c_r, halt_r, out_valid_r;
  m6502s_pkg::dec_t dec_r, dec_now;
  m6502s_pkg::out_t out_r;

  logic        ram_we;
  logic [15:0] ram_addr;
  logic [7:0]  ram_wd, ram_rd;
  logic [7:0]  idx, zp_sum, alu_val, asl_val;
  logic [8:0]  adc_sum;
  logic [15:0] ab_sum, ret;
  logic [7:0]  sp_inc, sp_dec;
  logic        out_free;

  m6502s_ram #(.WIDTH(8), .DEPTH(m6502s_pkg::MEM_DEPTH)) u_mem (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wd),
    .rdata (ram_rd)
  );

  assign dec_now  = m6502s_pkg::decode(ram_rd);
  assign out_free = !out_valid_r || out_ready;
  assign sp_inc   = sp_r + 8'd1;
  assign sp_dec   = sp_r - 8'd1;
  assign ret      = pc_r - 16'd1;
  assign idx      = (dec_r.mode == m6502s_pkg::AM_ZPX || dec_r.mode == m6502s_pkg::AM_ABX) ? x_r :
                    (dec_r.mode == m6502s_pkg::AM_ZPY || dec_r.mode == m6502s_pkg::AM_ABY) ? y_r :
                    8'd0;
  assign zp_sum   = ram_rd + idx;
  assign ab_sum   = {ram_rd, lo_r} + {8'd0, idx};
  assign adc_sum  = {1'b0, a_r} + {1'b0, ram_rd} + {8'd0, c_r};
  assign asl_val  = {ram_rd[6:0], 1'b0};

  always_comb begin
    case (dec_r.grp)
      m6502s_pkg::OG_AND: alu_val = a_r & ram_rd;
      m6502s_pkg::OG_ADC: alu_val = adc_sum[7:0];
      m6502s_pkg::OG_ASL: alu_val = asl_val;
      default:            alu_val = ram_rd;
    endcase
  end

  // memory port selection
  always_comb begin
    ram_we   = 1'b0;
    ram_addr = pc_r;
    ram_wd   = 8'd0;
    case (cmd.uop)
      m6502s_pkg::UOP_CLR: begin
        ram_we   = 1'b1;
        ram_addr = clr_cnt_r;
        ram_wd   = (clr_cnt_r == m6502s_pkg::RESET_PC) ? m6502s_pkg::OPC_JMP_ABS : 8'd0;
      end
      m6502s_pkg::UOP_WR: begin
        ram_we   = 1'b1;
        ram_addr = addr_r;
        ram_wd   = data_r;
      end
      m6502s_pkg::UOP_RD:   ram_addr = addr_r;
      m6502s_pkg::UOP_EXRD: ram_addr = ea_r;
      m6502s_pkg::UOP_EXEC: begin
        ram_addr = ea_r;
        ram_we   = (dec_r.grp == m6502s_pkg::OG_ASL);
        ram_wd   = asl_val;
      end
      m6502s_pkg::UOP_PUSH_HI: begin
        ram_we   = 1'b1;
        ram_addr = {m6502s_pkg::STACK_PAGE, sp_r};
        ram_wd   = ret[15:8];
      end
      m6502s_pkg::UOP_PUSH_LO: begin
        ram_we   = 1'b1;
        ram_addr = {m6502s_pkg::STACK_PAGE, sp_r};
        ram_wd   = ret[7:0];
      end
      m6502s_pkg::UOP_PULL_LO, m6502s_pkg::UOP_PULL_HI:
        ram_addr = {m6502s_pkg::STACK_PAGE, sp_inc};
      default: ram_addr = pc_r;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      pc_r        <= m6502s_pkg::RESET_PC;
      sp_r        <= m6502s_pkg::RESET_SP;
      a_r         <= '0;
      x_r         <= '0;
      y_r         <= '0;
      n_r         <= 1'b0;
      v_r         <= 1'b0;
      z_r         <= 1'b0;
      c_r         <= 1'b0;
      halt_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // a new result replaces a taken one in the same cycle
      if (cmd.uop == m6502s_pkg::UOP_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.uop)
        m6502s_pkg::UOP_CLR: clr_cnt_r <= clr_cnt_r + 16'd1;
        m6502s_pkg::UOP_FOP: pc_r <= pc_r + 16'd1;
        m6502s_pkg::UOP_DEC: begin
          if (!dec_now.ok) begin
            halt_r <= 1'b1;
          end else if (dec_now.grp == m6502s_pkg::OG_ASLA) begin
            c_r <= a_r[7];
            a_r <= {a_r[6:0], 1'b0};
            z_r <= (a_r[6:0] == 7'd0);
            n_r <= a_r[6];
          end else if (dec_now.mode != m6502s_pkg::AM_NONE) begin
            pc_r <= pc_r + 16'd1;
          end
        end
        m6502s_pkg::UOP_AB_LO: pc_r <= pc_r + 16'd1;
        m6502s_pkg::UOP_AB_HI: begin
          if (dec_r.grp == m6502s_pkg::OG_JMP) pc_r <= ab_sum;
        end
        m6502s_pkg::UOP_EXEC: begin
          z_r <= (alu_val == 8'd0);
          n_r <= alu_val[7];
          case (dec_r.grp)
            m6502s_pkg::OG_LDX: x_r <= alu_val;
            m6502s_pkg::OG_LDY: y_r <= alu_val;
            m6502s_pkg::OG_ASL: c_r <= ram_rd[7];
            m6502s_pkg::OG_ADC: begin
              a_r <= alu_val;
              c_r <= adc_sum[8];
              v_r <= ~(a_r[7] ^ ram_rd[7]) & (a_r[7] ^ adc_sum[7]);
            end
            default: a_r <= alu_val;
          endcase
        end
        m6502s_pkg::UOP_PUSH_HI: sp_r <= sp_dec;
        m6502s_pkg::UOP_PUSH_LO: begin
          sp_r <= sp_dec;
          pc_r <= ea_r;
        end
        m6502s_pkg::UOP_PULL_LO, m6502s_pkg::UOP_PULL_HI: sp_r <= sp_inc;
        m6502s_pkg::UOP_RTS_END: pc_r <= {ram_rd, lo_r} + 16'd1;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.uop)
      m6502s_pkg::UOP_ACCEPT: begin
        cmd_r  <= in_cmd;
        addr_r <= in_addr;
        data_r <= in_data;
        rd_r   <= 8'd0;
      end
      m6502s_pkg::UOP_RDW: rd_r <= ram_rd;
      m6502s_pkg::UOP_DEC: begin
        dec_r <= dec_now;
        ea_r  <= pc_r;
      end
      m6502s_pkg::UOP_ZP_ADR: ea_r <= {8'd0, zp_sum};
      m6502s_pkg::UOP_AB_LO:  lo_r <= ram_rd;
      m6502s_pkg::UOP_AB_HI:  ea_r <= ab_sum;
      m6502s_pkg::UOP_PULL_HI: lo_r <= ram_rd;
      m6502s_pkg::UOP_DONE: begin
        if (out_free) begin
          out_r <= '{read_data: rd_r, acc: a_r, x_reg: x_r, y_reg: y_r,
                     prog_counter: pc_r, stack_ptr: sp_r, flag_n: n_r,
                     flag_v: v_r, flag_z: z_r, flag_c: c_r, halted: halt_r};
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign stat.clr_last = (clr_cnt_r == 16'hFFFF);
  assign stat.cmd      = cmd_r;
  assign stat.halt     = halt_r;
  assign stat.dec_now  = dec_now;
  assign stat.dec_r    = dec_r;
  assign stat.out_free = out_free;

`ifndef SYNTHESIS
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r) else $error("halt cleared without reset");

  a_halt_at_decode: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(halt_r) |-> $past(cmd.uop == m6502s_pkg::UOP_DEC))
    else $error("halt set outside decode");

  a_sp_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$stable(sp_r) |->
      (sp_r == $past(sp_r) + 8'd1 || sp_r == $past(sp_r) - 8'd1))
    else $error("stack pointer moved by more than one");
`endif
endmodule

// ===== rtl/mos6502_subset_core.sv =====
// top level of the 6502 subset core with its own 64 KiB memory
//
//  channel | direction | transfer carries
//  in_ch   | in        | cmd, addr, data
//  out_ch  | out       | read_data, registers, flags, halted
//
// each command steps through the single memory port; an instruction does so in
// its fetch, operand bytes, data access and stack steps as it needs them
// after reset a clearing pass over all 65536 memory bytes runs before the first command transfer
// the result register holds a finished result while the next command is taken;
// the sequencer waits at its last step while the result is still untaken
module mos6502_subset_core (
  input  logic               clk,
  input  logic               rst_n,
  m6502s_in_if.sink          in_ch,
  m6502s_out_if.source       out_ch
);
  m6502s_pkg::ctrl_stat_t stat;
  m6502s_pkg::ctrl_cmd_t  cmd;
  m6502s_pkg::out_t       out_data;
  logic                   ready;

  // sequencer
  m6502s_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // registers, memory and result stage
  m6502s_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_cmd    (in_ch.cmd),
    .in_addr   (in_ch.addr),
    .in_data   (in_ch.data),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_data  (out_data)
  );

  assign in_ch.ready         = ready;
  assign out_ch.read_data    = out_data.read_data;
  assign out_ch.acc          = out_data.acc;
  assign out_ch.x_reg        = out_data.x_reg;
  assign out_ch.y_reg        = out_data.y_reg;
  assign out_ch.prog_counter = out_data.prog_counter;
  assign out_ch.stack_ptr    = out_data.stack_ptr;
  assign out_ch.flag_n       = out_data.flag_n;
  assign out_ch.flag_v       = out_data.flag_v;
  assign out_ch.flag_z       = out_data.flag_z;
  assign out_ch.flag_c       = out_data.flag_c;
  assign out_ch.halted       = out_data.halted;
endmodule
